/* hw/rtl/gda_pkg.sv */
package gda_pkg;

	localparam int ACC_W = 23;
	localparam int YR_W  = 15;

	localparam logic [21:0] MAX_SERIAL = 22'd3652059;

	localparam logic [ACC_W-1:0] DAYS_400Y  = 23'd146097;
	localparam logic [ACC_W-1:0] DAYS_100Y  = 23'd36524;
	localparam logic [ACC_W-1:0] DAYS_4Y    = 23'd1461;
	localparam logic [ACC_W-1:0] DAYS_1Y    = 23'd365;
	localparam logic [ACC_W-1:0] MONTHS_1Y  = 23'd12;

	// reciprocal of 100 scaled by 2^19, exact for year values below 43690
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [12:0] DAYS_PER_YR = 13'd365;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_ADD  = 1'b1;

	localparam logic [1:0] SEASON_WINTER = 2'd0;
	localparam logic [1:0] SEASON_SPRING = 2'd1;
	localparam logic [1:0] SEASON_SUMMER = 2'd2;
	localparam logic [1:0] SEASON_AUTUMN = 2'd3;

	typedef struct packed {
		logic        action;
		logic [15:0] day_count;
		logic [7:0]  month_in;
		logic [13:0] year_in;
	} req_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [13:0] year_out;
		logic [21:0] serial_day;
		logic [1:0]  season;
		logic        overflow;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

	// zero-based month index
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1:                   len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [1:0] season_of(input logic [3:0] m);
		logic [1:0] s;
		case (m) inside
			4'd0, 4'd1, 4'd11: s = SEASON_WINTER;
			[4'd2:4'd4]:       s = SEASON_SPRING;
			[4'd5:4'd7]:       s = SEASON_SUMMER;
			default:           s = SEASON_AUTUMN;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/gda_alu.sv */
module gda_alu (
	input  logic [gda_pkg::ACC_W-1:0] a,
	input  logic [gda_pkg::ACC_W-1:0] b,
	input  logic                      sub,
	output logic [gda_pkg::ACC_W-1:0] res,
	output logic                      ge
);

	logic [gda_pkg::ACC_W:0] diff;
	logic [gda_pkg::ACC_W-1:0] sum;

	assign diff = {1'b0, a} - {1'b0, b};
	assign sum  = a + b;
	assign ge   = ~diff[gda_pkg::ACC_W];
	assign res  = sub ? diff[gda_pkg::ACC_W-1:0] : sum;

endmodule

/* hw/rtl/gda_core.sv */
module gda_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  gda_pkg::req_t       req,
	input  logic                out_free,
	output gda_pkg::core_stat_t stat,
	output gda_pkg::rsp_t       result
);

	typedef enum logic [16:0] {
		S_IDLE = 17'b00000000000000001,
		S_MDIV = 17'b00000000000000010,
		S_MUL1 = 17'b00000000000000100,
		S_MUL2 = 17'b00000000000001000,
		S_LEAP = 17'b00000000000010000,
		S_A2   = 17'b00000000000100000,
		S_A3   = 17'b00000000001000000,
		S_MSUM = 17'b00000000010000000,
		S_DAY  = 17'b00000000100000000,
		S_SAT  = 17'b00000001000000000,
		S_DEC  = 17'b00000010000000000,
		S_D400 = 17'b00000100000000000,
		S_D100 = 17'b00001000000000000,
		S_D4   = 17'b00010000000000000,
		S_D1   = 17'b00100000000000000,
		S_MON  = 17'b01000000000000000,
		S_DONE = 17'b10000000000000000
	} state_t;

	localparam int RECIP_SHIFT_HI = gda_pkg::RECIP_SHIFT + 7;

	state_t state_q;

	logic [gda_pkg::ACC_W-1:0] acc_q;
	logic [gda_pkg::YR_W-1:0]  yr_q;
	logic [3:0]                mo_q;
	logic [3:0]                cnt_q;
	logic [15:0]               dd_q;
	logic [7:0]                q100_q;
	logic                      leap_q;
	logic [21:0]               ser_q;
	logic                      ovf_q;
	logic [1:0]                n100_q;
	logic [4:0]                n4_q;
	logic [1:0]                n1_q;

	logic [gda_pkg::ACC_W-1:0] alu_a;
	logic [gda_pkg::ACC_W-1:0] alu_b;
	logic                      alu_sub;
	logic [gda_pkg::ACC_W-1:0] alu_res;
	logic                      alu_ge;

	logic [12:0]               mul_k;
	logic [27:0]               mul;
	logic [gda_pkg::YR_W-1:0]  prod100;
	logic [gda_pkg::YR_W-1:0]  rem100;
	logic                      leap_ld;
	logic                      leap_dec;

	gda_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res),
		.ge  (alu_ge)
	);

	assign mul_k = (state_q == S_MUL1) ? gda_pkg::RECIP_100 : gda_pkg::DAYS_PER_YR;
	assign mul   = 28'(yr_q) * 28'(mul_k);

	assign prod100  = gda_pkg::YR_W'(q100_q) * 15'd100;
	assign rem100   = yr_q - prod100;
	assign leap_ld  = (yr_q[1:0] == 2'd3) && ((rem100 != 15'd99) || (q100_q[1:0] == 2'd3));
	assign leap_dec = (n1_q == 2'd3) && ((n4_q != 5'd24) || (n100_q == 2'd3));

	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_IDLE: begin
				alu_a = gda_pkg::ACC_W'(ser_q);
				alu_b = gda_pkg::ACC_W'(req.day_count);
			end
			S_MDIV: begin
				alu_b   = gda_pkg::MONTHS_1Y;
				alu_sub = 1'b1;
			end
			S_LEAP: alu_b = gda_pkg::ACC_W'(yr_q[gda_pkg::YR_W-1:2]);
			S_A2: begin
				alu_b   = gda_pkg::ACC_W'(q100_q);
				alu_sub = 1'b1;
			end
			S_A3:   alu_b = gda_pkg::ACC_W'(q100_q[7:2]);
			S_MSUM: alu_b = gda_pkg::ACC_W'(gda_pkg::month_len(cnt_q, leap_q));
			S_DAY:  alu_b = gda_pkg::ACC_W'(dd_q);
			S_SAT: begin
				alu_b   = gda_pkg::ACC_W'(gda_pkg::MAX_SERIAL) + 23'd1;
				alu_sub = 1'b1;
			end
			S_DEC: begin
				alu_b   = 23'd1;
				alu_sub = 1'b1;
			end
			S_D400: begin
				alu_b   = gda_pkg::DAYS_400Y;
				alu_sub = 1'b1;
			end
			S_D100: begin
				alu_b   = gda_pkg::DAYS_100Y;
				alu_sub = 1'b1;
			end
			S_D4: begin
				alu_b   = gda_pkg::DAYS_4Y;
				alu_sub = 1'b1;
			end
			S_D1: begin
				alu_b   = gda_pkg::DAYS_1Y;
				alu_sub = 1'b1;
			end
			S_MON: begin
				alu_b   = gda_pkg::ACC_W'(gda_pkg::month_len(mo_q, leap_q));
				alu_sub = 1'b1;
			end
			default: begin
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ser_q   <= 22'd1;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (req.action == gda_pkg::ACTION_ADD) ? S_SAT : S_MDIV;
					end
				end
				S_MDIV: if (!alu_ge) state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_LEAP;
				S_LEAP: state_q <= S_A2;
				S_A2:   state_q <= S_A3;
				S_A3:   state_q <= S_MSUM;
				S_MSUM: if (cnt_q == mo_q) state_q <= S_DAY;
				S_DAY:  state_q <= S_SAT;
				S_SAT: begin
					state_q <= S_DEC;
					ovf_q   <= alu_ge;
					ser_q   <= alu_ge ? gda_pkg::MAX_SERIAL : acc_q[21:0];
				end
				S_DEC:  state_q <= S_D400;
				S_D400: if (!alu_ge) state_q <= S_D100;
				S_D100: if (!(alu_ge && n100_q != 2'd3)) state_q <= S_D4;
				S_D4:   if (!alu_ge) state_q <= S_D1;
				S_D1:   if (!(alu_ge && n1_q != 2'd3)) state_q <= S_MON;
				S_MON:  if (!(alu_ge && mo_q != 4'd11)) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.action == gda_pkg::ACTION_ADD) begin
					acc_q <= alu_res;
				end else begin
					acc_q <= gda_pkg::ACC_W'((req.month_in != 8'd0) ? req.month_in - 8'd1 : 8'd0);
				end
				yr_q <= (req.year_in != 14'd0) ? gda_pkg::YR_W'(req.year_in) - 15'd1 : '0;
				dd_q <= (req.day_count != 16'd0) ? req.day_count : 16'd1;
			end
			S_MDIV: begin
				if (alu_ge) begin
					acc_q <= alu_res;
					yr_q  <= yr_q + 15'd1;
				end else begin
					mo_q <= acc_q[3:0];
				end
			end
			S_MUL1: q100_q <= mul[RECIP_SHIFT_HI:gda_pkg::RECIP_SHIFT];
			S_MUL2: acc_q <= mul[gda_pkg::ACC_W-1:0];
			S_LEAP: begin
				acc_q  <= alu_res;
				leap_q <= leap_ld;
			end
			S_A2: acc_q <= alu_res;
			S_A3: begin
				acc_q <= alu_res;
				cnt_q <= 4'd0;
			end
			S_MSUM: begin
				if (cnt_q != mo_q) begin
					acc_q <= alu_res;
					cnt_q <= cnt_q + 4'd1;
				end
			end
			S_DAY: acc_q <= alu_res;
			S_SAT: acc_q <= alu_ge ? gda_pkg::ACC_W'(gda_pkg::MAX_SERIAL) : acc_q;
			S_DEC: begin
				acc_q  <= alu_res;
				yr_q   <= '0;
				mo_q   <= 4'd0;
				n100_q <= 2'd0;
				n4_q   <= 5'd0;
				n1_q   <= 2'd0;
			end
			S_D400: begin
				if (alu_ge) begin
					acc_q <= alu_res;
					yr_q  <= yr_q + 15'd400;
				end
			end
			S_D100: begin
				if (alu_ge && n100_q != 2'd3) begin
					acc_q  <= alu_res;
					yr_q   <= yr_q + 15'd100;
					n100_q <= n100_q + 2'd1;
				end
			end
			S_D4: begin
				if (alu_ge) begin
					acc_q <= alu_res;
					yr_q  <= yr_q + 15'd4;
					n4_q  <= n4_q + 5'd1;
				end
			end
			S_D1: begin
				if (alu_ge && n1_q != 2'd3) begin
					acc_q <= alu_res;
					yr_q  <= yr_q + 15'd1;
					n1_q  <= n1_q + 2'd1;
				end else begin
					leap_q <= leap_dec;
				end
			end
			S_MON: begin
				if (alu_ge && mo_q != 4'd11) begin
					acc_q <= alu_res;
					mo_q  <= mo_q + 4'd1;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE) && out_free;

	assign result.day_out    = acc_q[4:0] + 5'd1;
	assign result.month_out  = mo_q + 4'd1;
	assign result.year_out   = yr_q[13:0] + 14'd1;
	assign result.serial_day = ser_q;
	assign result.season     = gda_pkg::season_of(mo_q);
	assign result.overflow   = ovf_q;

	a_ser_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ser_q <= gda_pkg::MAX_SERIAL) && (ser_q != 22'd0))
		else $error("stored serial out of range");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (mo_q <= 4'd11))
		else $error("month index past December");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |->
		(acc_q < gda_pkg::ACC_W'(gda_pkg::month_len(mo_q, leap_q))))
		else $error("day index past month end");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && ovf_q) |->
		((ser_q == gda_pkg::MAX_SERIAL) && (yr_q == 15'd9998)))
		else $error("overflow without saturated date");

endmodule

/* hw/rtl/gregorian_date_accumulator.sv */
// Keeps one Gregorian date and returns, per request, the normalized date, its serial
// day number (0001-01-01 is day 1), season and a saturation flag. One request is
// processed at a time; req_ready is low while it runs, and the next request may be
// taken while the previous response still waits in the output register. A single
// 23-bit add/subtract unit walks, one step per cycle, for a load the month carry,
// the leap days and the days before the month, and for a load or an add splits
// the serial number into 400/100/4/1-year blocks and months.
module gregorian_date_accumulator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gda_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gda_pkg::rsp_t rsp
);

	gda_pkg::core_stat_t stat;
	gda_pkg::rsp_t       result;
	logic                start;
	logic                out_free;
	logic                rsp_valid_q;
	gda_pkg::rsp_t       rsp_q;

	assign req_ready = stat.idle;
	assign start     = req_valid && stat.idle;
	assign out_free  = !rsp_valid_q || rsp_ready;

	gda_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.out_free (out_free),
		.stat     (stat),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
